### hdl/dmr_pkg.sv
// shared types and constants for the digest modular reduce block
`default_nettype none

package dmr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 64;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned CountW = 6;

  localparam logic [WordW-1:0] ModulusReset = WordW'(256);
  localparam logic [WordW-1:0] OffsetReset  = '0;

  // register select is address bit 3 (8-byte spacing)
  localparam logic RegModulus = 1'b0;
  localparam logic RegOffset  = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] digest_byte;
    logic             last_byte;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] number;
    logic             bad_modulus;
  } out_t;

endpackage

`default_nettype wire

### hdl/digest_modular_reduce_core.sv
// digest modular reduce core: horner reduction of a big-endian byte string
`default_nettype none

// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------
// in       | input     | in_valid_i / in_stall_o    | in_data_i  (digest_byte, last)
// out      | output    | out_valid_o / out_stall_i  | out_data_o (number, bad_mod)
// apb      | input     | psel, penable, pwrite      | paddr, pwdata, prdata
//
// a byte is accepted while idle, then shifted bit by bit through the shared shift-subtract unit
// after a modulus rewrite mid-digest, a remainder not below it first goes bit by bit through the same unit
// a final byte then waits in StEmit to form remainder + offset into the output register
// rst_ni clears remainder, state and output valid; modulus resets to 256
// in_stall_o is high while a transaction is being worked on
// a waiting output transaction only stalls the block when a new result is ready

module digest_modular_reduce_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire dmr_pkg::in_t          in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output dmr_pkg::out_t              out_data_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [dmr_pkg::AddrW-1:0] paddr,
  input  wire logic [dmr_pkg::WordW-1:0] pwdata,
  output logic [dmr_pkg::WordW-1:0]  prdata,
  output logic                       pready
);
  import dmr_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StReduce,
    StStep,
    StEmit
  } state_e;

  state_e            state_q, state_d;
  logic [WordW-1:0]  modulus_q, offset_q;
  logic [WordW-1:0]  rem_q, rem_d;
  logic [WordW-1:0]  src_q, src_d;     // bits fed into the unit, msb first
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic              last_q, last_d;
  logic              bad_q, bad_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              in_acc, out_free, cfg_wr;

  // shared unit: one shift-in and conditional subtract
  logic [WordW:0]    trial;
  logic              borrow;
  logic [WordW:0]    diff;
  logic [WordW-1:0]  step_rem;

  assign trial             = {rem_q, src_q[WordW-1]};
  assign {borrow, diff}    = {1'b0, trial} - {2'b00, modulus_q};
  assign step_rem          = borrow ? trial[WordW-1:0] : diff[WordW-1:0];

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration port, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == RegOffset) ? offset_q : modulus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
      offset_q  <= OffsetReset;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        RegModulus: modulus_q <= pwdata;
        RegOffset:  offset_q  <= pwdata;
        default:    ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    src_d       = src_q;
    cnt_d       = cnt_q;
    byte_d      = byte_q;
    last_d      = last_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          byte_d = in_data_i.digest_byte;
          last_d = in_data_i.last_byte;
          bad_d  = 1'b0;
          if (modulus_q == '0) begin
            // zero divisor: drop remainder, report on the final byte
            rem_d = '0;
            bad_d = 1'b1;
            if (in_data_i.last_byte) begin
              state_d = StEmit;
            end
          end else if (rem_q >= modulus_q) begin
            // divisor changed mid-digest: reduce old remainder bit by bit
            src_d   = rem_q;
            rem_d   = '0;
            cnt_d   = CountW'(WordW - 1);
            state_d = StReduce;
          end else begin
            src_d   = {in_data_i.digest_byte, {(WordW-ByteW){1'b0}}};
            cnt_d   = CountW'(ByteW - 1);
            state_d = StStep;
          end
        end
      end
      StReduce: begin
        rem_d = step_rem;
        src_d = {src_q[WordW-2:0], 1'b0};
        cnt_d = cnt_q - CountW'(1);
        if (cnt_q == '0) begin
          src_d   = {byte_q, {(WordW-ByteW){1'b0}}};
          cnt_d   = CountW'(ByteW - 1);
          state_d = StStep;
        end
      end
      StStep: begin
        rem_d = step_rem;
        src_d = {src_q[WordW-2:0], 1'b0};
        cnt_d = cnt_q - CountW'(1);
        if (cnt_q == '0) begin
          state_d = last_q ? StEmit : StIdle;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.number      = bad_q ? '0 : rem_q + offset_q;
          out_d.bad_modulus = bad_q;
          rem_d             = '0;
          state_d           = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    cnt_q  <= cnt_d;
    byte_q <= byte_d;
    last_q <= last_d;
    bad_q  <= bad_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

### hdl/dmr_checker.sv
// port-level assertions for the digest modular reduce core, with bind
`default_nettype none

module dmr_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire dmr_pkg::out_t             out_data_o
);
  import dmr_pkg::*;

  // a stalled output transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // no result appears in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // a new result only comes out of a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work in flight");

  // error results carry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_modulus |-> out_data_o.number == '0)
    else $error("bad modulus result with nonzero number");

endmodule

bind digest_modular_reduce_core dmr_checker u_dmr_checker (.*);

`default_nettype wire
